// ----- src/bmm_pkg.sv -----
// ----------------------------------------------------------------------------
// bmm_pkg
// Shared widths, codes and state type of the banked memory map.
// ----------------------------------------------------------------------------
package bmm_pkg;

   // field widths
   localparam int ADDR_W      = 24;
   localparam int DATA_W      = 32;
   localparam int WORD_W      = 16;
   localparam int BYTE_W      = 8;
   localparam int ACTION_W    = 3;
   localparam int SIZE_W      = 2;
   localparam int SPAN_W      = 17;
   localparam int REGION_W    = 2;
   localparam int BANK_W      = 8;
   localparam int BANKS       = 256;
   localparam int OFFSET_W    = 19;
   localparam int CSR_INDEX_W = 2;

   // action codes
   localparam logic [ACTION_W-1:0] ACT_MAP   = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_READ  = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_WRITE = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_CHECK = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_LOAD  = 3'd4;

   // access sizes (code 3 behaves as long)
   localparam logic [SIZE_W-1:0] SZ_BYTE = 2'd0;
   localparam logic [SIZE_W-1:0] SZ_WORD = 2'd1;

   // region codes
   localparam logic [REGION_W-1:0] REG_CHIP = 2'd0;
   localparam logic [REGION_W-1:0] REG_SLOW = 2'd1;
   localparam logic [REGION_W-1:0] REG_ROM  = 2'd2;
   localparam logic [REGION_W-1:0] REG_EXT  = 2'd3;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_CHIP_OFFSET = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOW_OFFSET = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROM_OFFSET  = 2'd2;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_MAP,
      ST_READ_HI,
      ST_READ_LO,
      ST_MERGE,
      ST_WRITE_LO
   } state_type;

endpackage

// ----- src/bmm_req_if.sv -----
// ----------------------------------------------------------------------------
// bmm_req_if
// Request channel: valid, ready and one access beat.
// ----------------------------------------------------------------------------
interface bmm_req_if import bmm_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [ACTION_W-1:0]   action;
   logic [ADDR_W-1:0]     address;
   logic [SIZE_W-1:0]     size_code;
   logic [DATA_W-1:0]     write_data;
   logic [BANK_W-1:0]     bank_start;
   logic [SPAN_W-1:0]     span;
   logic [REGION_W-1:0]   map_target;

   modport source (
      output valid, action, address, size_code, write_data, bank_start, span,
             map_target,
      input  ready
   );

   modport sink (
      input  valid, action, address, size_code, write_data, bank_start, span,
             map_target,
      output ready
   );
endinterface

// ----- src/bmm_rsp_if.sv -----
// ----------------------------------------------------------------------------
// bmm_rsp_if
// Response channel: valid, ready and one result beat.
// ----------------------------------------------------------------------------
interface bmm_rsp_if import bmm_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [DATA_W-1:0]     read_data;
   logic [REGION_W-1:0]   region;
   logic                  in_range;
   logic                  external_hit;

   modport source (
      output valid, read_data, region, in_range, external_hit,
      input  ready
   );

   modport sink (
      input  valid, read_data, region, in_range, external_hit,
      output ready
   );
endinterface

// ----- src/bmm_ram.sv -----
// ----------------------------------------------------------------------------
// bmm_ram
// Generic one-write, one-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module bmm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/banked_memory_map_access.sv -----
// ----------------------------------------------------------------------------
// banked_memory_map_access
// 24-bit address map: a bank table routes each 64K bank to chip RAM, slow RAM,
// ROM or external; big-endian byte, word and long access to 16-bit stores.
// ----------------------------------------------------------------------------
//
//   channel    dir   handshake          beat contents
//   req_chan   in    valid / ready      action, address, size, data, map args
//   rsp_chan   out   valid / ready      read data, region, range, external
//   csr_*      in    csr_write          register index, offset value
//
// per beat, check, word write, rom write and external hit end in lookup; byte
// write adds merge, long write write_lo, short read read_hi, long read read_hi
// and read_lo; map a state per filled entry; load and unused actions end in
// idle. registered table and store reads; one store word and one table entry
// per cycle. results pass a hold register and the response register, so a
// waiting response does not stop the next request. reset clears the table via
// per-bank valid bits at once; no clearing pass; no request taken in reset.
//
module banked_memory_map_access import bmm_pkg::*; #(
   parameter int CHIP_BYTES = 524288,
   parameter int SLOW_BYTES = 524288,
   parameter int ROM_BYTES  = 524288
) (
   input  logic                   clock,
   input  logic                   reset,
   bmm_req_if.sink                req_chan,
   bmm_rsp_if.source              rsp_chan,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [OFFSET_W-1:0]    csr_data
);

   localparam int CHIP_AW = $clog2(CHIP_BYTES);
   localparam int SLOW_AW = $clog2(SLOW_BYTES);
   localparam int ROM_AW  = $clog2(ROM_BYTES);
   localparam int SUM_W   = ADDR_W + 1;
   localparam int MAP_W   = BANK_W + 1;

   // configuration
   logic [OFFSET_W-1:0] chip_offset_ff;
   logic [OFFSET_W-1:0] slow_offset_ff;
   logic [OFFSET_W-1:0] rom_offset_ff;

   // sequencer and latched request
   state_type           state_ff, state_in;
   logic [ACTION_W-1:0] action_ff;
   logic [ADDR_W-1:0]   addr_ff;
   logic [SIZE_W-1:0]   size_ff;
   logic [DATA_W-1:0]   wdata_ff;
   logic [BANK_W-1:0]   bstart_ff;
   logic [SPAN_W-1:0]   span_ff;
   logic [REGION_W-1:0] target_ff;
   logic [MAP_W-1:0]    map_i_ff;
   logic                bank_hit_ff;
   logic [REGION_W-1:0] region_ff;
   logic [WORD_W-1:0]   hi_word_ff;
   logic [BANKS-1:0]    bank_valid_ff;

   // hold and response registers
   logic                hold_valid_ff;
   logic [DATA_W-1:0]   hold_rdata_ff;
   logic [REGION_W-1:0] hold_region_ff;
   logic                hold_inr_ff;
   logic                hold_ext_ff;
   logic                rsp_valid_ff;
   logic [DATA_W-1:0]   rsp_rdata_ff;
   logic [REGION_W-1:0] rsp_region_ff;
   logic                rsp_inr_ff;
   logic                rsp_ext_ff;

   logic accept;
   logic out_free;
   logic move;

   // finishing beat
   logic                fin;
   logic [DATA_W-1:0]   fin_rdata;
   logic [REGION_W-1:0] fin_region;
   logic                fin_inr;
   logic                fin_ext;

   // table port
   logic                tbl_we;
   logic [REGION_W-1:0] tbl_rdata;
   logic [MAP_W-1:0]    map_entry;
   logic                map_more;

   // address translation
   logic [ADDR_W-1:0]   chip_base, slow_base, rom_base;
   logic [CHIP_AW-1:0]  chip_off;
   logic [SLOW_AW-1:0]  slow_off;
   logic [ROM_AW-1:0]   rom_off;
   logic [CHIP_AW-2:0]  chip_w0, chip_w1;
   logic [SLOW_AW-2:0]  slow_w0, slow_w1;
   logic [ROM_AW-2:0]   rom_w0, rom_w1;
   logic [REGION_W-1:0] lk_region;
   logic [REGION_W-1:0] cur_region;
   logic [ADDR_W-1:0]   lk_off;
   logic [SUM_W-1:0]    lk_bytes;
   logic                lk_inr;
   logic                cur_odd;
   logic                is_long;

   // store ports
   logic                mem_we;
   logic                mem_use_w1;
   logic [WORD_W-1:0]   mem_wdata;
   logic [WORD_W-1:0]   mem_rdata;
   logic [WORD_W-1:0]   chip_rdata, slow_rdata, rom_rdata;
   logic                rom_we;

   // handshakes
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign move     = hold_valid_ff && out_free;
   assign req_chan.ready = !reset && (state_ff == ST_IDLE) && (!hold_valid_ff || move);
   assign accept   = req_chan.valid && req_chan.ready;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         chip_offset_ff <= '0;
         slow_offset_ff <= '0;
         rom_offset_ff  <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_CHIP_OFFSET: chip_offset_ff <= csr_data;
            CSR_SLOW_OFFSET: slow_offset_ff <= csr_data;
            CSR_ROM_OFFSET:  rom_offset_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // offset translation for every region in parallel
   assign chip_base = {{(ADDR_W-OFFSET_W){1'b0}}, chip_offset_ff};
   assign slow_base = {{(ADDR_W-OFFSET_W){1'b0}}, slow_offset_ff};
   assign rom_base  = {{(ADDR_W-OFFSET_W){1'b0}}, rom_offset_ff};
   assign chip_off  = addr_ff[CHIP_AW-1:0] - chip_base[CHIP_AW-1:0];
   assign slow_off  = addr_ff[SLOW_AW-1:0] - slow_base[SLOW_AW-1:0];
   assign rom_off   = addr_ff[ROM_AW-1:0]  - rom_base[ROM_AW-1:0];
   assign chip_w0   = chip_off[CHIP_AW-1:1];
   assign slow_w0   = slow_off[SLOW_AW-1:1];
   assign rom_w0    = rom_off[ROM_AW-1:1];
   assign chip_w1   = chip_w0 + (CHIP_AW-1)'(1);
   assign slow_w1   = slow_w0 + (SLOW_AW-1)'(1);
   assign rom_w1    = rom_w0  + (ROM_AW-1)'(1);

   // region of the latched address and the range check
   assign lk_region  = bank_hit_ff ? tbl_rdata : REG_CHIP;
   assign cur_region = (state_ff == ST_LOOKUP) ? lk_region : region_ff;
   assign is_long    = size_ff[1];

   always_comb begin
      case (cur_region)
         REG_SLOW: begin
            lk_off   = ADDR_W'(slow_off);
            lk_bytes = SUM_W'(SLOW_BYTES);
         end
         REG_ROM: begin
            lk_off   = ADDR_W'(rom_off);
            lk_bytes = SUM_W'(ROM_BYTES);
         end
         default: begin
            lk_off   = ADDR_W'(chip_off);
            lk_bytes = SUM_W'(CHIP_BYTES);
         end
      endcase
   end

   assign cur_odd = lk_off[0];
   assign lk_inr  = (SUM_W'(lk_off) + SUM_W'(span_ff)) < lk_bytes;

   // map sweep position
   assign map_entry = MAP_W'(bstart_ff) + map_i_ff;
   assign map_more  = (SPAN_W'(map_i_ff) < span_ff) && !map_entry[BANK_W];

   // read data of the store that the access went to
   always_comb begin
      case (region_ff)
         REG_SLOW: mem_rdata = slow_rdata;
         REG_ROM:  mem_rdata = rom_rdata;
         default:  mem_rdata = chip_rdata;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_chan.action == ACT_MAP) begin
                  state_in = ST_MAP;
               end else if (req_chan.action inside {ACT_READ, ACT_WRITE, ACT_CHECK}) begin
                  state_in = ST_LOOKUP;
               end
            end
         end
         ST_LOOKUP: begin
            state_in = ST_IDLE;
            if (lk_region != REG_EXT) begin
               if (action_ff == ACT_READ) begin
                  state_in = ST_READ_HI;
               end else if (action_ff == ACT_WRITE && lk_region != REG_ROM) begin
                  if (size_ff == SZ_BYTE) begin
                     state_in = ST_MERGE;
                  end else if (is_long) begin
                     state_in = ST_WRITE_LO;
                  end
               end
            end
         end
         ST_MAP:      state_in = map_more ? ST_MAP : ST_IDLE;
         ST_READ_HI:  state_in = is_long ? ST_READ_LO : ST_IDLE;
         ST_READ_LO:  state_in = ST_IDLE;
         ST_MERGE:    state_in = ST_IDLE;
         ST_WRITE_LO: state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      fin        = 1'b0;
      fin_rdata  = '0;
      fin_region = REG_CHIP;
      fin_inr    = 1'b0;
      fin_ext    = 1'b0;
      tbl_we     = 1'b0;
      mem_we     = 1'b0;
      mem_use_w1 = 1'b0;
      mem_wdata  = wdata_ff[WORD_W-1:0];
      rom_we     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // load and unused actions finish at once
            if (accept && !(req_chan.action inside {ACT_MAP, ACT_READ, ACT_WRITE,
                                                     ACT_CHECK})) begin
               fin = 1'b1;
               if (req_chan.action == ACT_LOAD) begin
                  rom_we     = 1'b1;
                  fin_region = REG_ROM;
               end
            end
         end
         ST_LOOKUP: begin
            fin_region = lk_region;
            if (lk_region == REG_EXT) begin
               fin     = 1'b1;
               fin_ext = 1'b1;
            end else if (action_ff == ACT_CHECK) begin
               fin     = 1'b1;
               fin_inr = lk_inr;
            end else if (action_ff == ACT_WRITE) begin
               if (lk_region == REG_ROM) begin
                  fin = 1'b1;
               end else if (size_ff == SZ_WORD) begin
                  fin    = 1'b1;
                  mem_we = 1'b1;
               end else if (is_long) begin
                  mem_we    = 1'b1;
                  mem_wdata = wdata_ff[DATA_W-1:WORD_W];
               end
            end
         end
         ST_MAP: begin
            fin_region = target_ff;
            if (map_more) begin
               tbl_we = 1'b1;
            end else begin
               fin = 1'b1;
            end
         end
         ST_READ_HI: begin
            // second word of a long is read here
            mem_use_w1 = 1'b1;
            fin_region = region_ff;
            if (!is_long) begin
               fin = 1'b1;
               if (size_ff == SZ_BYTE) begin
                  fin_rdata = DATA_W'(cur_odd ? mem_rdata[BYTE_W-1:0]
                                              : mem_rdata[WORD_W-1:BYTE_W]);
               end else begin
                  fin_rdata = DATA_W'(mem_rdata);
               end
            end
         end
         ST_READ_LO: begin
            fin        = 1'b1;
            fin_region = region_ff;
            fin_rdata  = {hi_word_ff, mem_rdata};
         end
         ST_MERGE: begin
            // byte write: replace one half of the word just read
            fin        = 1'b1;
            fin_region = region_ff;
            mem_we     = 1'b1;
            mem_wdata  = cur_odd ? {mem_rdata[WORD_W-1:BYTE_W], wdata_ff[BYTE_W-1:0]}
                                 : {wdata_ff[BYTE_W-1:0], mem_rdata[BYTE_W-1:0]};
         end
         ST_WRITE_LO: begin
            fin        = 1'b1;
            fin_region = region_ff;
            mem_we     = 1'b1;
            mem_use_w1 = 1'b1;
         end
         default: ;
      endcase
   end

   // sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // request beat and working registers
   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff   <= req_chan.action;
         addr_ff     <= req_chan.address;
         size_ff     <= req_chan.size_code;
         wdata_ff    <= req_chan.write_data;
         bstart_ff   <= req_chan.bank_start;
         span_ff     <= req_chan.span;
         target_ff   <= req_chan.map_target;
         bank_hit_ff <= bank_valid_ff[req_chan.address[ADDR_W-1:ADDR_W-BANK_W]];
         map_i_ff    <= '0;
      end else if (tbl_we) begin
         map_i_ff <= map_i_ff + MAP_W'(1);
      end
      if (state_ff == ST_LOOKUP) begin
         region_ff <= lk_region;
      end
      if (state_ff == ST_READ_HI) begin
         hi_word_ff <= mem_rdata;
      end
   end

   // bank valid bits: unmapped banks read as chip RAM
   always_ff @(posedge clock) begin
      if (reset) begin
         bank_valid_ff <= '0;
      end else if (tbl_we) begin
         bank_valid_ff[map_entry[BANK_W-1:0]] <= 1'b1;
      end
   end

   // hold register
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else if (fin) begin
         hold_valid_ff <= 1'b1;
      end else if (move) begin
         hold_valid_ff <= 1'b0;
      end
      if (fin) begin
         hold_rdata_ff  <= fin_rdata;
         hold_region_ff <= fin_region;
         hold_inr_ff    <= fin_inr;
         hold_ext_ff    <= fin_ext;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= hold_valid_ff;
      end
      if (move) begin
         rsp_rdata_ff  <= hold_rdata_ff;
         rsp_region_ff <= hold_region_ff;
         rsp_inr_ff    <= hold_inr_ff;
         rsp_ext_ff    <= hold_ext_ff;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.read_data    = rsp_rdata_ff;
   assign rsp_chan.region       = rsp_region_ff;
   assign rsp_chan.in_range     = rsp_inr_ff;
   assign rsp_chan.external_hit = rsp_ext_ff;

   // bank table, read at the address of the incoming beat
   bmm_ram #(
      .WIDTH (REGION_W),
      .DEPTH (256)
   ) u_bank_table (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (map_entry[BANK_W-1:0]),
      .wr_data (target_ff),
      .rd_addr (req_chan.address[ADDR_W-1:ADDR_W-BANK_W]),
      .rd_data (tbl_rdata)
   );

   // chip RAM words
   bmm_ram #(
      .WIDTH (WORD_W),
      .DEPTH (CHIP_BYTES / 2)
   ) u_chip_store (
      .clock   (clock),
      .wr_en   (mem_we && cur_region == REG_CHIP),
      .wr_addr (mem_use_w1 ? chip_w1 : chip_w0),
      .wr_data (mem_wdata),
      .rd_addr (mem_use_w1 ? chip_w1 : chip_w0),
      .rd_data (chip_rdata)
   );

   // slow RAM words
   bmm_ram #(
      .WIDTH (WORD_W),
      .DEPTH (SLOW_BYTES / 2)
   ) u_slow_store (
      .clock   (clock),
      .wr_en   (mem_we && cur_region == REG_SLOW),
      .wr_addr (mem_use_w1 ? slow_w1 : slow_w0),
      .wr_data (mem_wdata),
      .rd_addr (mem_use_w1 ? slow_w1 : slow_w0),
      .rd_data (slow_rdata)
   );

   // ROM words, written only by load beats
   bmm_ram #(
      .WIDTH (WORD_W),
      .DEPTH (ROM_BYTES / 2)
   ) u_rom_store (
      .clock   (clock),
      .wr_en   (rom_we),
      .wr_addr (req_chan.address[ROM_AW-1:1]),
      .wr_data (req_chan.write_data[WORD_W-1:0]),
      .rd_addr (mem_use_w1 ? rom_w1 : rom_w0),
      .rd_data (rom_rdata)
   );

endmodule

// ----- dv/banked_memory_map_access_tb.sv -----
// ----------------------------------------------------------------------------
// banked_memory_map_access_tb
// Self-checking bench for the banked memory map. A queue of access beats feeds
// a paced driver; a monitor predicts every reply from its own copy of the
// bank table, the offsets and the three word stores, and compares it field by
// field. Reads only go to bytes that some earlier beat wrote or loaded.
// ----------------------------------------------------------------------------
module banked_memory_map_access_tb;
   import bmm_pkg::*;

   localparam int CHIP_BYTES       = 524288;
   localparam int SLOW_BYTES       = 524288;
   localparam int ROM_BYTES        = 524288;
   localparam int STORE_WORDS      = 262144;
   localparam int PHASES           = 6;
   localparam int RANDOM_PER_PHASE = 270;
   localparam int RECENT_DEPTH     = 256;
   localparam int SETTLE_CYCLES    = 300;

   // codes the package leaves unnamed
   localparam logic [SIZE_W-1:0]   SZ_LONG          = 2'd2;
   localparam logic [SIZE_W-1:0]   SZ_LONG_ALT      = 2'd3;
   localparam logic [ACTION_W-1:0] ACT_UNUSED_FIRST = 3'd5;
   localparam logic [ACTION_W-1:0] ACT_UNUSED_LAST  = 3'd7;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [ADDR_W-1:0]   address;
      logic [SIZE_W-1:0]   size_code;
      logic [DATA_W-1:0]   write_data;
      logic [BANK_W-1:0]   bank_start;
      logic [SPAN_W-1:0]   span;
      logic [REGION_W-1:0] map_target;
   } access_t;

   typedef struct packed {
      logic [DATA_W-1:0]   read_data;
      logic [REGION_W-1:0] region;
      logic                in_range;
      logic                external_hit;
   } reply_t;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [OFFSET_W-1:0]    csr_data;

   bmm_req_if req_if ();
   bmm_rsp_if rsp_if ();

   banked_memory_map_access dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   // predicted block state
   logic [REGION_W-1:0] bank_map [0:BANKS-1];
   bit [WORD_W-1:0]     store_word [0:2][0:STORE_WORDS-1];
   logic [OFFSET_W-1:0] offset_reg [0:2];

   // what the stimulus side knows ahead of the block: table and written lanes
   logic [REGION_W-1:0] plan_map [0:BANKS-1];
   bit [1:0]            lane_written [0:2][0:STORE_WORDS-1];
   int unsigned         recent_words [$];

   access_t pending_access_q [$];
   reply_t  expected_reply_q [$];
   access_t on_wire;
   logic    req_taken = 1'b0;
   logic    rsp_taken = 1'b0;
   int      send_gap = 0;
   int      hold_off = 0;
   int      sent_count = 0;
   int      reply_count = 0;
   int      fail_count = 0;

   function automatic int unsigned region_bytes(logic [REGION_W-1:0] rgn);
      case (rgn)
         REG_CHIP: return CHIP_BYTES;
         REG_SLOW: return SLOW_BYTES;
         default:  return ROM_BYTES;
      endcase
   endfunction

   // byte offset inside a region after the offset register is taken off
   function automatic int unsigned local_off(logic [REGION_W-1:0] rgn,
                                             logic [ADDR_W-1:0] addr);
      int unsigned mask;
      int unsigned base;
      int unsigned full;
      mask = region_bytes(rgn) - 1;
      base = offset_reg[rgn];
      full = addr;
      return (full - (base & mask)) & mask;
   endfunction

   // expected reply for one beat; updates the predicted state
   function automatic reply_t predict_reply(access_t a);
      reply_t              r;
      logic [REGION_W-1:0] rgn;
      int unsigned         off;
      int unsigned         w0;
      int unsigned         w1;
      int unsigned         idx;
      r = '0;
      case (a.action)
         ACT_MAP: begin
            for (int i = 0; i < int'(a.span) && int'(a.bank_start) + i < BANKS; i++)
               bank_map[int'(a.bank_start) + i] = a.map_target;
            r.region = a.map_target;
         end
         ACT_READ, ACT_WRITE, ACT_CHECK: begin
            rgn = bank_map[a.address[ADDR_W-1 -: BANK_W]];
            r.region = rgn;
            if (rgn == REG_EXT) begin
               r.external_hit = 1'b1;
            end else begin
               off = local_off(rgn, a.address);
               w0  = off >> 1;
               w1  = (w0 + 1) & (region_bytes(rgn) / 2 - 1);
               if (a.action == ACT_READ) begin
                  case (a.size_code)
                     SZ_BYTE: r.read_data = off[0] ? store_word[rgn][w0][7:0]
                                                   : store_word[rgn][w0][15:8];
                     SZ_WORD: r.read_data = store_word[rgn][w0];
                     default: r.read_data = {store_word[rgn][w0], store_word[rgn][w1]};
                  endcase
               end else if (a.action == ACT_WRITE) begin
                  // rom ignores bus writes
                  if (rgn != REG_ROM) begin
                     case (a.size_code)
                        SZ_BYTE: begin
                           if (off[0]) store_word[rgn][w0][7:0] = a.write_data[7:0];
                           else store_word[rgn][w0][15:8] = a.write_data[7:0];
                        end
                        SZ_WORD: store_word[rgn][w0] = a.write_data[15:0];
                        default: begin
                           store_word[rgn][w0] = a.write_data[31:16];
                           store_word[rgn][w1] = a.write_data[15:0];
                        end
                     endcase
                  end
               end else begin
                  r.in_range = (off + a.span < region_bytes(rgn));
               end
            end
         end
         ACT_LOAD: begin
            idx = (a.address & (ROM_BYTES - 1)) >> 1;
            store_word[REG_ROM][idx] = a.write_data[15:0];
            r.region = REG_ROM;
         end
         default: ;
      endcase
      return r;
   endfunction

   // queue a beat and track which store lanes it leaves defined
   function automatic void enqueue(access_t a);
      logic [REGION_W-1:0] rgn;
      int unsigned         off;
      int unsigned         w0;
      int                  note;
      note = -1;
      case (a.action)
         ACT_MAP: begin
            for (int i = 0; i < int'(a.span) && int'(a.bank_start) + i < BANKS; i++)
               plan_map[int'(a.bank_start) + i] = a.map_target;
         end
         ACT_WRITE: begin
            rgn = plan_map[a.address[ADDR_W-1 -: BANK_W]];
            if (rgn != REG_EXT && rgn != REG_ROM) begin
               off = local_off(rgn, a.address);
               w0  = off >> 1;
               if (a.size_code == SZ_BYTE) begin
                  lane_written[rgn][w0] |= off[0] ? 2'b01 : 2'b10;
               end else begin
                  lane_written[rgn][w0] = 2'b11;
                  if (a.size_code != SZ_WORD)
                     lane_written[rgn][(w0 + 1) & (region_bytes(rgn) / 2 - 1)] = 2'b11;
               end
               note = (int'(rgn) << 18) | int'(w0);
            end
         end
         ACT_LOAD: begin
            w0 = (a.address & (ROM_BYTES - 1)) >> 1;
            lane_written[REG_ROM][w0] = 2'b11;
            note = (int'(REG_ROM) << 18) | int'(w0);
         end
         default: ;
      endcase
      if (note >= 0) begin
         recent_words.push_back(note);
         if (recent_words.size() > RECENT_DEPTH) void'(recent_words.pop_front());
      end
      pending_access_q.push_back(a);
   endfunction

   function automatic access_t make_beat(logic [ACTION_W-1:0] action,
                                         logic [ADDR_W-1:0] address,
                                         logic [SIZE_W-1:0] size_code,
                                         logic [DATA_W-1:0] write_data,
                                         logic [BANK_W-1:0] bank_start,
                                         logic [SPAN_W-1:0] span,
                                         logic [REGION_W-1:0] map_target);
      access_t a;
      a.action     = action;
      a.address    = address;
      a.size_code  = size_code;
      a.write_data = write_data;
      a.bank_start = bank_start;
      a.span       = span;
      a.map_target = map_target;
      return a;
   endfunction

   // aim a read at defined bytes: first the random address, then recent words
   function automatic bit pick_read(inout access_t a);
      logic [REGION_W-1:0] rgn;
      int unsigned         entry;
      int unsigned         want;
      int unsigned         bank_mask;
      int unsigned         first;
      int unsigned         b;
      int unsigned         off;
      int unsigned         w0;
      int unsigned         w1;
      bit                  ok;
      for (int t = 0; t < 8; t++) begin
         if (t > 0) begin
            if (recent_words.size() == 0) return 1'b0;
            entry = recent_words[$urandom_range(0, recent_words.size() - 1)];
            rgn   = REGION_W'(entry >> 18);
            want  = (((entry & 32'h3ffff) << 1) + $urandom_range(0, 1) + offset_reg[rgn])
                    & (region_bytes(rgn) - 1);
            bank_mask = (region_bytes(rgn) >> 16) - 1;
            first = $urandom_range(0, BANKS - 1);
            ok = 1'b0;
            b  = 0;
            for (int k = 0; k < BANKS && !ok; k++) begin
               b = (first + k) % BANKS;
               if (plan_map[b] == rgn && (b & bank_mask) == (want >> 16)) ok = 1'b1;
            end
            if (!ok) continue;
            a.address = {BANK_W'(b), 16'(want)};
            if (t > 4) a.size_code = SZ_BYTE;
         end
         rgn = plan_map[a.address[ADDR_W-1 -: BANK_W]];
         if (rgn == REG_EXT) return 1'b1;
         off = local_off(rgn, a.address);
         w0  = off >> 1;
         w1  = (w0 + 1) & (region_bytes(rgn) / 2 - 1);
         case (a.size_code)
            SZ_BYTE: ok = lane_written[rgn][w0][off[0] ? 0 : 1];
            SZ_WORD: ok = lane_written[rgn][w0] == 2'b11;
            default: ok = lane_written[rgn][w0] == 2'b11 && lane_written[rgn][w1] == 2'b11;
         endcase
         if (ok) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic access_t random_access();
      access_t     a;
      int unsigned roll;
      a.address = ADDR_W'($urandom());
      if ($urandom_range(0, 1) == 1) a.address[15:0] = 16'($urandom_range(0, 63));
      a.size_code  = SIZE_W'($urandom_range(0, 3));
      a.write_data = $urandom();
      a.bank_start = BANK_W'($urandom_range(0, BANKS - 1));
      roll = $urandom_range(0, 9);
      if (roll < 6) a.span = SPAN_W'($urandom_range(1, 8));
      else if (roll < 8) a.span = SPAN_W'($urandom_range(0, 300));
      else a.span = SPAN_W'($urandom_range(0, 65536));
      a.map_target = ($urandom_range(0, 9) == 0) ? REG_EXT : REGION_W'($urandom_range(0, 2));
      roll = $urandom_range(0, 99);
      if (roll < 6) a.action = ACT_MAP;
      else if (roll < 46) a.action = pick_read(a) ? ACT_READ : ACT_WRITE;
      else if (roll < 80) a.action = ACT_WRITE;
      else if (roll < 88) a.action = ACT_CHECK;
      else if (roll < 97) a.action = ACT_LOAD;
      else a.action = ACTION_W'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST));
      return a;
   endfunction

   function automatic logic [OFFSET_W-1:0] phase_offset(int phase);
      if (phase == 0) return '0;
      if (phase == 1) return '1;
      return OFFSET_W'($urandom_range(0, (1 << OFFSET_W) - 1));
   endfunction

   // register write while the block is idle
   task automatic write_offset(logic [CSR_INDEX_W-1:0] idx, logic [REGION_W-1:0] rgn,
                               logic [OFFSET_W-1:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      offset_reg[rgn] = value;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   // request driver: one beat per pop; no gap in the first 60 of every 240 beats, else a random gap
   always @(negedge clock) begin : access_driver
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_taken) begin
         if (send_gap > 0) begin
            send_gap = send_gap - 1;
            req_if.valid <= 1'b0;
         end else if (pending_access_q.size() > 0) begin
            on_wire = pending_access_q.pop_front();
            req_if.action     <= on_wire.action;
            req_if.address    <= on_wire.address;
            req_if.size_code  <= on_wire.size_code;
            req_if.write_data <= on_wire.write_data;
            req_if.bank_start <= on_wire.bank_start;
            req_if.span       <= on_wire.span;
            req_if.map_target <= on_wire.map_target;
            req_if.valid      <= 1'b1;
            sent_count = sent_count + 1;
            send_gap = (sent_count % 240 < 60) ? 0 : $urandom_range(0, 3);
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // reply side back-pressure
   always @(negedge clock) begin : reply_pacing
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_taken) hold_off = (reply_count % 200 >= 150) ? 0 : $urandom_range(0, 3);
         if (hold_off > 0) begin
            hold_off = hold_off - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // reply checker and prediction on accepted request beats
   always @(posedge clock) begin : reply_monitor
      reply_t want;
      req_taken <= !reset && req_if.valid && req_if.ready;
      rsp_taken <= !reset && rsp_if.valid && rsp_if.ready;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            reply_count = reply_count + 1;
            if (expected_reply_q.size() == 0) begin
               $error("reply beat with no access pending");
               fail_count = fail_count + 1;
            end else begin
               want = expected_reply_q.pop_front();
               if (rsp_if.read_data !== want.read_data) begin
                  $error("read_data: expected %h, got %h", want.read_data, rsp_if.read_data);
                  fail_count = fail_count + 1;
               end
               if (rsp_if.region !== want.region) begin
                  $error("region: expected %0d, got %0d", want.region, rsp_if.region);
                  fail_count = fail_count + 1;
               end
               if (rsp_if.in_range !== want.in_range) begin
                  $error("in_range: expected %b, got %b", want.in_range, rsp_if.in_range);
                  fail_count = fail_count + 1;
               end
               if (rsp_if.external_hit !== want.external_hit) begin
                  $error("external_hit: expected %b, got %b", want.external_hit,
                         rsp_if.external_hit);
                  fail_count = fail_count + 1;
               end
            end
         end
         if (req_if.valid && req_if.ready) expected_reply_q.push_back(predict_reply(on_wire));
      end
   end

   initial begin
      req_if.valid      = 1'b0;
      req_if.action     = ACT_MAP;
      req_if.address    = '0;
      req_if.size_code  = SZ_BYTE;
      req_if.write_data = '0;
      req_if.bank_start = '0;
      req_if.span       = '0;
      req_if.map_target = REG_CHIP;
      rsp_if.ready      = 1'b0;
      csr_write         = 1'b0;
      csr_index         = CSR_CHIP_OFFSET;
      csr_data          = '0;
      for (int b = 0; b < BANKS; b++) begin
         bank_map[b] = REG_CHIP;
         plan_map[b] = REG_CHIP;
      end
      offset_reg[REG_CHIP] = '0;
      offset_reg[REG_SLOW] = '0;
      offset_reg[REG_ROM]  = '0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int p = 0; p < PHASES; p++) begin
         write_offset(CSR_CHIP_OFFSET, REG_CHIP, phase_offset(p));
         write_offset(CSR_SLOW_OFFSET, REG_SLOW, phase_offset(p));
         write_offset(CSR_ROM_OFFSET, REG_ROM, phase_offset(p));

         if (p == 0) begin
            // big-endian lanes and odd word address
            enqueue(make_beat(ACT_WRITE, 24'h000000, SZ_LONG, 32'hdeadbeef, 0, 0, REG_CHIP));
            enqueue(make_beat(ACT_READ, 24'h000000, SZ_LONG, 0, 0, 0, REG_CHIP));
            enqueue(make_beat(ACT_READ, 24'h000001, SZ_WORD, 0, 0, 0, REG_CHIP));
            enqueue(make_beat(ACT_READ, 24'h000000, SZ_BYTE, 0, 0, 0, REG_CHIP));
            enqueue(make_beat(ACT_READ, 24'h000003, SZ_BYTE, 0, 0, 0, REG_CHIP));
            enqueue(make_beat(ACT_WRITE, 24'h000002, SZ_BYTE, 32'hffffff5a, 0, 0, REG_CHIP));
            enqueue(make_beat(ACT_READ, 24'h000002, SZ_WORD, 0, 0, 0, REG_CHIP));
            // long access wrapping at the top of the region, size code three
            enqueue(make_beat(ACT_WRITE, 24'h07fffe, SZ_LONG, 32'h01234567, 0, 0, REG_CHIP));
            enqueue(make_beat(ACT_READ, 24'h07ffff, SZ_LONG_ALT, 0, 0, 0, REG_CHIP));
            // slow ram bank
            enqueue(make_beat(ACT_MAP, 0, SZ_BYTE, 0, 8'h10, 1, REG_SLOW));
            enqueue(make_beat(ACT_WRITE, 24'h100000, SZ_WORD, 32'hffffffff, 0, 0, REG_CHIP));
            enqueue(make_beat(ACT_READ, 24'h100001, SZ_BYTE, 0, 0, 0, REG_CHIP));
            // rom: load, dropped write, read back
            enqueue(make_beat(ACT_MAP, 0, SZ_BYTE, 0, 8'h20, 1, REG_ROM));
            enqueue(make_beat(ACT_LOAD, 24'hf00100, SZ_LONG_ALT, 32'h1234a5c3, 0, 0, REG_CHIP));
            enqueue(make_beat(ACT_WRITE, 24'h200100, SZ_WORD, 32'h0, 0, 0, REG_CHIP));
            enqueue(make_beat(ACT_READ, 24'h200100, SZ_WORD, 0, 0, 0, REG_CHIP));
            // external bank
            enqueue(make_beat(ACT_MAP, 0, SZ_BYTE, 0, 8'h30, 1, REG_EXT));
            enqueue(make_beat(ACT_READ, 24'h30abcd, SZ_LONG, 0, 0, 0, REG_CHIP));
            enqueue(make_beat(ACT_WRITE, 24'h300000, SZ_WORD, 32'h5555aaaa, 0, 0, REG_CHIP));
            enqueue(make_beat(ACT_CHECK, 24'h300000, SZ_BYTE, 0, 0, 4, REG_CHIP));
            // range check boundary and largest length
            enqueue(make_beat(ACT_CHECK, 24'h07fff0, SZ_BYTE, 0, 0, 15, REG_CHIP));
            enqueue(make_beat(ACT_CHECK, 24'hffffff, SZ_BYTE, 0, 0, 1, REG_CHIP));
            enqueue(make_beat(ACT_CHECK, 24'h000000, SZ_BYTE, 0, 0, 65536, REG_CHIP));
            // map spans: huge, past the table end, empty
            enqueue(make_beat(ACT_MAP, 0, SZ_BYTE, 0, 8'h40, 65536, REG_CHIP));
            enqueue(make_beat(ACT_MAP, 0, SZ_BYTE, 0, 8'hfa, 20, REG_SLOW));
            enqueue(make_beat(ACT_MAP, 0, SZ_BYTE, 0, 8'h00, 0, REG_ROM));
            // unused actions
            enqueue(make_beat(ACT_UNUSED_FIRST, 24'hffffff, SZ_LONG_ALT, 32'hffffffff,
                              8'hff, 65536, REG_EXT));
            enqueue(make_beat(ACT_UNUSED_LAST, 24'h123456, SZ_WORD, 32'h89abcdef,
                              8'h5a, 7, REG_SLOW));
         end

         for (int n = 0; n < RANDOM_PER_PHASE; n++) enqueue(random_access());

         // drain, then let a long map fill finish before touching registers
         while (pending_access_q.size() != 0 || expected_reply_q.size() != 0 || req_if.valid)
            @(posedge clock);
         repeat (SETTLE_CYCLES) @(posedge clock);
      end

      if (fail_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

   // hang guard
   initial begin
      #20000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
